// File: sv/gbfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfl_pkg
// Shared constants, types and helpers of the bilinear field grid lookup.
// ----------------------------------------------------------------------------
package gbfl_pkg;

   // grid geometry in degrees
   localparam int STEP_DEG    = 10;
   localparam int LAT_MIN_DEG = -90;
   localparam int LAT_MAX_DEG = 90;
   localparam int LON_MIN_DEG = -180;
   localparam int LON_MAX_DEG = 180;

   localparam longint UNITS_PER_DEG = 64'sd10000000;
   localparam longint STEP_U = longint'(STEP_DEG) * UNITS_PER_DEG;
   localparam longint LAT_LO = longint'(LAT_MIN_DEG) * UNITS_PER_DEG;
   localparam longint LAT_HI = longint'(LAT_MAX_DEG) * UNITS_PER_DEG;
   localparam longint LON_LO = longint'(LON_MIN_DEG) * UNITS_PER_DEG;
   localparam longint LON_HI = longint'(LON_MAX_DEG) * UNITS_PER_DEG;

   localparam int GRID_ROWS = (LAT_MAX_DEG - LAT_MIN_DEG) / STEP_DEG + 1;
   localparam int GRID_COLS = (LON_MAX_DEG - LON_MIN_DEG) / STEP_DEG + 1;
   localparam int GRID_SIZE = GRID_ROWS * GRID_COLS;
   localparam int ROW_LAST  = (GRID_ROWS >= 2) ? GRID_ROWS - 2 : 0;
   localparam int COL_LAST  = (GRID_COLS >= 2) ? GRID_COLS - 2 : 0;

   // field widths
   localparam int ROW_W  = 5;
   localparam int COL_W  = 6;
   localparam int VAL_W  = 32;
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int ADDR_W = $clog2(GRID_SIZE);

   // datapath widths of the coordinate locator
   localparam int CRD_W    = 33;
   localparam int D_W      = 32;
   localparam int S_W      = 30;
   localparam int Q_W      = 9;
   localparam int OFF_W    = 30;
   localparam int RECIP_SH = 48;
   localparam int RECIP_W  = 25;
   localparam int FE_SH    = 32;
   localparam int FE_W     = 18;
   localparam int FRAC_W   = 17;
   localparam longint RECIP = (64'sd1 <<< RECIP_SH) / STEP_U;
   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   // item codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic [1:0] SEL_INTENSITY   = 2'd0;
   localparam logic [1:0] SEL_DECLINATION = 2'd1;
   localparam logic [1:0] SEL_INCLINATION = 2'd2;

   localparam int NUM_GRIDS = 3;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  data;
   } grid_wr_type;

   typedef struct packed {
      logic [VAL_W-1:0] intensity;
      logic [VAL_W-1:0] declination;
      logic [VAL_W-1:0] inclination;
      logic             in_range;
   } rsp_type;

   function automatic logic [ADDR_W-1:0] grid_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      grid_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(GRID_COLS)) + ADDR_W'(col);
   endfunction

endpackage
`default_nettype wire

// File: sv/gbfl_locate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfl_locate
// Seven-stage coordinate locator: clamp, cell index by reciprocal multiply
// with one correction, top-cell clamp, Q1.16 fraction with saturation.
// ----------------------------------------------------------------------------
module gbfl_locate import gbfl_pkg::*; #(
   parameter longint LO     = LAT_LO,
   parameter longint HI     = LAT_HI,
   parameter int     LAST   = ROW_LAST,
   parameter int     CELL_W = ROW_W
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [CRD_W-1:0]  coord,
   output logic [CELL_W-1:0]        cell_idx,
   output logic [FRAC_W-1:0]        frac,
   output logic                     hit
);

   localparam int QS_W = Q_W + S_W;
   localparam int R_W  = FE_W + S_W;
   localparam logic signed [CRD_W-1:0] LO_C = CRD_W'(LO);
   localparam logic signed [CRD_W-1:0] HI_C = CRD_W'(HI);
   localparam logic [S_W-1:0]     STEP_C   = S_W'(STEP_U);
   localparam logic [OFF_W-1:0]   STEP_O   = OFF_W'(STEP_U);
   localparam logic [R_W-1:0]     STEP_R   = R_W'(STEP_U);
   localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
   localparam logic [Q_W-1:0]     LAST_Q   = Q_W'(LAST);
   localparam logic [D_W-1:0]     LAST_OFF = D_W'(longint'(LAST) * STEP_U);

   logic signed [CRD_W-1:0] clamp_in;
   logic [CRD_W-1:0]        dist_in;
   logic [D_W+RECIP_W-1:0]  quot_in;
   logic [QS_W-1:0]         rem_in;
   logic                    corr_in;
   logic [Q_W-1:0]          qc_in;
   logic [OFF_W-1:0]        offc_in;
   logic [CELL_W-1:0]       cell_in;
   logic [OFF_W-1:0]        off_in;
   logic [OFF_W+RECIP_W-1:0] fe_in;
   logic [R_W-1:0]          fres_in;

   logic [6:0]        hit_ff;
   logic [D_W-1:0]    d1_ff, d2_ff, d3_ff;
   logic [Q_W-1:0]    q2_ff, q3_ff;
   logic [OFF_W-1:0]  rem3_ff, off4_ff, off5_ff;
   logic [CELL_W-1:0] cell4_ff;
   logic [FE_W-1:0]   fe5_ff, fe6_ff;
   logic              sat5_ff, sat6_ff;
   logic [R_W-1:0]    r6_ff;
   logic [FRAC_W-1:0] frac7_ff;

   always_comb begin
      priority if (coord < LO_C) begin
         clamp_in = LO_C;
      end else if (coord > HI_C) begin
         clamp_in = HI_C;
      end else begin
         clamp_in = coord;
      end
      dist_in = clamp_in - LO_C;
      quot_in = d1_ff * RECIP_C;
      rem_in  = QS_W'(d2_ff) - QS_W'(q2_ff) * QS_W'(STEP_C);
      // quotient estimate is at most one low
      corr_in = rem3_ff >= STEP_O;
      qc_in   = q3_ff + Q_W'(corr_in);
      offc_in = corr_in ? rem3_ff - STEP_O : rem3_ff;
      if (qc_in > LAST_Q) begin
         cell_in = CELL_W'(LAST_Q);
         off_in  = OFF_W'(d3_ff - LAST_OFF);
      end else begin
         cell_in = CELL_W'(qc_in);
         off_in  = offc_in;
      end
      fe_in   = off4_ff * RECIP_C;
      fres_in = R_W'({off5_ff, 16'd0}) - R_W'(fe5_ff) * R_W'(STEP_C);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= {hit_ff[5:0], (coord <= LO_C) || (coord >= HI_C)};
         d1_ff    <= dist_in[D_W-1:0];
         d2_ff    <= d1_ff;
         q2_ff    <= quot_in[RECIP_SH +: Q_W];
         d3_ff    <= d2_ff;
         q3_ff    <= q2_ff;
         rem3_ff  <= rem_in[OFF_W-1:0];
         cell4_ff <= cell_in;
         off4_ff  <= off_in;
         fe5_ff   <= fe_in[FE_SH +: FE_W];
         sat5_ff  <= off4_ff >= STEP_O;
         off5_ff  <= off4_ff;
         fe6_ff   <= fe5_ff;
         sat6_ff  <= sat5_ff;
         r6_ff    <= fres_in;
         frac7_ff <= sat6_ff ? FRAC_ONE
                             : FRAC_W'(fe6_ff) + FRAC_W'(r6_ff >= STEP_R);
      end
   end

   assign cell_idx = cell4_ff;
   assign frac     = frac7_ff;
   assign hit      = hit_ff[6];

endmodule
`default_nettype wire

// File: sv/gbfl_grid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfl_grid
// One grid held in two copies, each with one write and two read ports, so
// that all four cell corners are read in the same cycle.
// ----------------------------------------------------------------------------
module gbfl_grid import gbfl_pkg::*; (
   input  logic                         clock,
   input  logic                         en,
   input  grid_wr_type                  wr,
   input  logic [3:0][ADDR_W-1:0]       raddr,
   output logic [3:0][VAL_W-1:0]        rdata
);

   logic [VAL_W-1:0] mem_a_ff [GRID_SIZE];
   logic [VAL_W-1:0] mem_b_ff [GRID_SIZE];
   logic [3:0][VAL_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_a_ff[wr.addr] <= wr.data;
         mem_b_ff[wr.addr] <= wr.data;
      end
      if (en) begin
         // south corners from one copy, north corners from the other
         rd_ff[0] <= mem_a_ff[raddr[0]];
         rd_ff[1] <= mem_a_ff[raddr[1]];
         rd_ff[2] <= mem_b_ff[raddr[2]];
         rd_ff[3] <= mem_b_ff[raddr[3]];
      end
   end

   assign rdata = rd_ff;

endmodule
`default_nettype wire

// File: sv/gbfl_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfl_lerp
// Six-stage bilinear interpolation: along longitude on both edges, then
// along latitude, products floored by arithmetic shift.
// ----------------------------------------------------------------------------
module gbfl_lerp import gbfl_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic [3:0][VAL_W-1:0]     corner,
   input  logic [FRAC_W-1:0]         fx,
   input  logic [FRAC_W-1:0]         fy,
   output logic [VAL_W-1:0]          result
);

   localparam int DIF_W = VAL_W + 1;
   localparam int PRD_W = FRAC_W + 1 + DIF_W;
   localparam int SHR_W = PRD_W - 16;

   logic signed [PRD_W-1:0] ps_in, pn_in, p2_in;
   logic signed [SHR_W-1:0] south_in, north_in, res_in;

   logic signed [VAL_W-1:0] sw8_ff, nw8_ff, sw9_ff, nw9_ff;
   logic signed [DIF_W-1:0] ds8_ff, dn8_ff;
   logic [FRAC_W-1:0]       fx8_ff;
   logic [FRAC_W-1:0]       fy8_ff, fy9_ff, fy10_ff, fy11_ff;
   logic signed [SHR_W-1:0] ps9_ff, pn9_ff, p12_ff;
   logic signed [DIF_W-1:0] s10_ff, n10_ff, s11_ff, d11_ff, s12_ff;
   logic [VAL_W-1:0]        res13_ff;

   always_comb begin
      ps_in    = $signed({1'b0, fx8_ff}) * ds8_ff;
      pn_in    = $signed({1'b0, fx8_ff}) * dn8_ff;
      south_in = SHR_W'(sw9_ff) + ps9_ff;
      north_in = SHR_W'(nw9_ff) + pn9_ff;
      p2_in    = $signed({1'b0, fy11_ff}) * d11_ff;
      res_in   = SHR_W'(s12_ff) + p12_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sw8_ff   <= $signed(corner[0]);
         nw8_ff   <= $signed(corner[2]);
         ds8_ff   <= DIF_W'($signed(corner[1])) - DIF_W'($signed(corner[0]));
         dn8_ff   <= DIF_W'($signed(corner[3])) - DIF_W'($signed(corner[2]));
         fx8_ff   <= fx;
         fy8_ff   <= fy;
         ps9_ff   <= SHR_W'(ps_in >>> 16);
         pn9_ff   <= SHR_W'(pn_in >>> 16);
         sw9_ff   <= sw8_ff;
         nw9_ff   <= nw8_ff;
         fy9_ff   <= fy8_ff;
         // edge values stay between their corners
         s10_ff   <= DIF_W'(south_in);
         n10_ff   <= DIF_W'(north_in);
         fy10_ff  <= fy9_ff;
         s11_ff   <= s10_ff;
         d11_ff   <= n10_ff - s10_ff;
         fy11_ff  <= fy10_ff;
         p12_ff   <= SHR_W'(p2_in >>> 16);
         s12_ff   <= s11_ff;
         res13_ff <= VAL_W'(res_in);
      end
   end

   assign result = res13_ff;

endmodule
`default_nettype wire

// File: sv/gbfl_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfl_skid
// Result output register with a skid word, so the pipeline keeps moving
// while one result waits.
// ----------------------------------------------------------------------------
module gbfl_skid import gbfl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_word
);

   logic    out_vld_ff, skid_vld_ff;
   rsp_type out_ff, skid_ff;

   assign in_ready = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || out_ready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= in_valid;
         end
      end else if (in_valid && in_ready) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || out_ready) begin
         out_ff <= skid_vld_ff ? skid_ff : in_word;
      end else if (in_valid && in_ready) begin
         skid_ff <= in_word;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_word  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid word held with empty output register");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(in_valid && out_vld_ff && !out_ready))
      else $error("skid filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      $fell(skid_vld_ff) |-> $past(out_ready))
      else $error("skid drained without output taken");

endmodule
`default_nettype wire

// File: sv/grid_bilinear_field_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_bilinear_field_lookup_top
// Three grids (intensity, declination, inclination) loaded by write words and
// read by query words that return bilinearly interpolated Q16.16 values.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                              tuser
//  req      in         row, col, value, lat, lon (112b)   action, table_select
//  rsp      out        intensity, decl, incl (96b)        in_range
//
//  one word accepted per cycle while the pipeline is not frozen; a query
//  passes the input register, 13 pipeline stages, then the output register
//  a write passes through its delay registers to the grid memories, in order
//  with queries, so a later query always sees it
//  reset clears valid bits only; grid contents are undefined until written
//  a stalled result is held in the output register, one more in a skid word;
//  the pipeline freezes only when both are full
// ----------------------------------------------------------------------------
module grid_bilinear_field_lookup_top import gbfl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // row_index[4:0], col_index[10:5], entry_value[42:11], latitude[73:43],
   // longitude[105:74], zero pad
   input  logic [111:0]  req_tdata,
   // action[0], table_select[2:1]
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // intensity[31:0], declination[63:32], inclination[95:64]
   output logic [95:0]   rsp_tdata,
   // in_range[0]
   output logic          rsp_tuser
);

   logic en;
   logic req_acc;

   logic [13:0] qv_ff;
   logic [4:0]  wv_ff;
   logic [1:0]       wsel_ff [5];
   logic [ROW_W-1:0] wrow_ff [5];
   logic [COL_W-1:0] wcol_ff [5];
   logic [VAL_W-1:0] wval_ff [5];
   logic signed [CRD_W-1:0] lat0_ff, lon0_ff;

   logic [ROW_W-1:0]  lat_cell;
   logic [COL_W-1:0]  lon_cell;
   logic [FRAC_W-1:0] fy, fx;
   logic              hit_lat, hit_lon;

   logic [ROW_W-1:0] r1_in;
   logic [COL_W-1:0] c1_in;
   logic [3:0][ADDR_W-1:0] ra_in, ra_ff;
   logic [NUM_GRIDS-1:0]   we_in, we_ff;
   logic [ADDR_W-1:0]      waddr_ff;
   logic [VAL_W-1:0]       wdata_ff;

   logic [3:0][VAL_W-1:0] rd   [NUM_GRIDS];
   logic [3:0][VAL_W-1:0] cor_ff [NUM_GRIDS];
   logic [VAL_W-1:0]      res  [NUM_GRIDS];
   logic [5:0]            ir_ff;

   rsp_type pipe_word, out_word;

   assign req_acc = req_tvalid && en;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= '0;
         wv_ff <= '0;
         we_ff <= '0;
      end else if (en) begin
         qv_ff <= {qv_ff[12:0], req_acc && (req_tuser[0] == ACT_QUERY)};
         wv_ff <= {wv_ff[3:0], req_acc && (req_tuser[0] == ACT_WRITE)};
         we_ff <= we_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wsel_ff[0] <= req_tuser[2:1];
         wrow_ff[0] <= req_tdata[4:0];
         wcol_ff[0] <= req_tdata[10:5];
         wval_ff[0] <= req_tdata[42:11];
         for (int i = 1; i < 5; i++) begin
            wsel_ff[i] <= wsel_ff[i-1];
            wrow_ff[i] <= wrow_ff[i-1];
            wcol_ff[i] <= wcol_ff[i-1];
            wval_ff[i] <= wval_ff[i-1];
         end
         lat0_ff  <= CRD_W'($signed(req_tdata[73:43]));
         lon0_ff  <= CRD_W'($signed(req_tdata[105:74]));
         ra_ff    <= ra_in;
         waddr_ff <= grid_addr(wrow_ff[4], wcol_ff[4]);
         wdata_ff <= wval_ff[4];
         for (int g = 0; g < NUM_GRIDS; g++) begin
            cor_ff[g] <= rd[g];
         end
         ir_ff <= {ir_ff[4:0], !(hit_lat || hit_lon)};
      end
   end

   // write decode; bad table or out-of-grid entries are dropped
   always_comb begin
      we_in = '0;
      if (wv_ff[4] && (wrow_ff[4] < ROW_W'(GRID_ROWS)) && (wcol_ff[4] < COL_W'(GRID_COLS)))
      begin
         unique case (wsel_ff[4])
            SEL_INTENSITY:   we_in[0] = 1'b1;
            SEL_DECLINATION: we_in[1] = 1'b1;
            SEL_INCLINATION: we_in[2] = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      r1_in = (32'(lat_cell) + 32'd1 < 32'(GRID_ROWS)) ? lat_cell + ROW_W'(1) : lat_cell;
      c1_in = (32'(lon_cell) + 32'd1 < 32'(GRID_COLS)) ? lon_cell + COL_W'(1) : lon_cell;
      ra_in[0] = grid_addr(lat_cell, lon_cell);
      ra_in[1] = grid_addr(lat_cell, c1_in);
      ra_in[2] = grid_addr(r1_in, lon_cell);
      ra_in[3] = grid_addr(r1_in, c1_in);
   end

   gbfl_locate #(.LO(LAT_LO), .HI(LAT_HI), .LAST(ROW_LAST), .CELL_W(ROW_W)) u_lat (
      .clock    (clock),
      .en       (en),
      .coord    (lat0_ff),
      .cell_idx (lat_cell),
      .frac     (fy),
      .hit      (hit_lat)
   );

   gbfl_locate #(.LO(LON_LO), .HI(LON_HI), .LAST(COL_LAST), .CELL_W(COL_W)) u_lon (
      .clock    (clock),
      .en       (en),
      .coord    (lon0_ff),
      .cell_idx (lon_cell),
      .frac     (fx),
      .hit      (hit_lon)
   );

   for (genvar g = 0; g < NUM_GRIDS; g++) begin : g_grid
      grid_wr_type wr;

      assign wr.we   = we_ff[g] && en;
      assign wr.addr = waddr_ff;
      assign wr.data = wdata_ff;

      gbfl_grid u_grid (
         .clock (clock),
         .en    (en),
         .wr    (wr),
         .raddr (ra_ff),
         .rdata (rd[g])
      );

      gbfl_lerp u_lerp (
         .clock  (clock),
         .en     (en),
         .corner (cor_ff[g]),
         .fx     (fx),
         .fy     (fy),
         .result (res[g])
      );
   end

   assign pipe_word.intensity   = res[0];
   assign pipe_word.declination = res[1];
   assign pipe_word.inclination = res[2];
   assign pipe_word.in_range    = ir_ff[5];

   gbfl_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qv_ff[13]),
      .in_ready  (en),
      .in_word   (pipe_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = {out_word.inclination, out_word.declination, out_word.intensity};
   assign rsp_tuser = out_word.in_range;

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(qv_ff) && $stable(wv_ff))
      else $error("pipeline moved while frozen");

endmodule
`default_nettype wire
